FILE: hdl/ppmp_pkg.sv
`timescale 1ns / 1ps

package ppmp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MAGIC     = 2'd1;
   localparam logic [1:0] ERR_NUMBER    = 2'd2;

   // Characters the parser looks for
   localparam logic [7:0] CHAR_P        = 8'h50;
   localparam logic [7:0] CHAR_SIX      = 8'h36;
   localparam logic [7:0] CHAR_HASH     = 8'h23;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   // Largest maximum value the format allows
   localparam int unsigned MAXV_LIMIT   = 65535;

   // One input word held in the input stage
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } ppmp_item_type;

   // One result word, valid marks that the byte produced a result
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] max_value;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  error_code;
      logic        last;
   } ppmp_result_type;

endpackage

FILE: hdl/ppmp_in_stage.sv
`timescale 1ns / 1ps

module ppmp_in_stage
   import ppmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_start_req,
   input  logic          advance,
   output logic          item_valid,
   output ppmp_item_type item
);

   logic          valid_ff;
   logic          valid_in;
   ppmp_item_type item_ff;

   // Take a new word when the stage is empty or its word moves on this cycle
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload only on accept, so a held word does not change
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.data_byte <= req_data_byte;
         item_ff.start_req <= req_start_req;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hdl/ppmp_parse.sv
`timescale 1ns / 1ps

module ppmp_parse
   import ppmp_pkg::*;
#(
   parameter int DIM_BITS = 16
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  ppmp_item_type   item,
   output ppmp_result_type result
);

   localparam int PIX_BITS = 2 * DIM_BITS;
   localparam int ACC_BITS = 16;
   localparam int MUL_BITS = 20;
   localparam logic [MUL_BITS-1:0] DIM_LIMIT = MUL_BITS'((1 << DIM_BITS) - 1);
   localparam logic [MUL_BITS-1:0] MAX_LIMIT = MUL_BITS'(MAXV_LIMIT);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_WIDTH,
      PH_HEIGHT,
      PH_MAXV,
      PH_PIX,
      PH_IDLE
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic                    comment_ff, comment_in;
   logic [1:0]              tok_len_ff, tok_len_in;
   logic [ACC_BITS-1:0]     acc_ff, acc_in;
   logic [DIM_BITS-1:0]     width_ff, width_in;
   logic [DIM_BITS-1:0]     height_ff, height_in;
   logic [PIX_BITS-1:0]     pix_left_ff, pix_left_in;
   logic [1:0]              sample_idx_ff, sample_idx_in;
   logic [7:0]              red_ff, red_in;
   logic [7:0]              green_ff, green_in;

   phase_type               cur_phase;
   logic                    cur_comment;
   logic [1:0]              cur_tok_len;
   logic [ACC_BITS-1:0]     cur_acc;
   logic [7:0]              b;
   logic                    is_ws;
   logic                    is_digit;
   logic [MUL_BITS-1:0]     acc_next;
   logic [MUL_BITS-1:0]     limit;
   logic [PIX_BITS-1:0]     pix_dec;
   ppmp_result_type         res;

   // A start word restarts the parse before its byte is taken
   always_comb begin
      cur_phase   = item.start_req ? PH_MAGIC : phase_ff;
      cur_comment = item.start_req ? 1'b0 : comment_ff;
      cur_tok_len = item.start_req ? 2'd0 : tok_len_ff;
      cur_acc     = item.start_req ? '0 : acc_ff;
   end

   // Classify the byte and build the next decimal value
   assign b        = item.data_byte;
   assign is_ws    = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign acc_next = (MUL_BITS'(cur_acc) << 3) + (MUL_BITS'(cur_acc) << 1)
                     + MUL_BITS'(b[3:0]);
   assign limit    = (cur_phase == PH_MAXV) ? MAX_LIMIT : DIM_LIMIT;
   assign pix_dec  = pix_left_ff - PIX_BITS'(1);

   // Per-byte parse step
   always_comb begin
      phase_in      = cur_phase;
      comment_in    = cur_comment;
      tok_len_in    = cur_tok_len;
      acc_in        = cur_acc;
      width_in      = width_ff;
      height_in     = height_ff;
      pix_left_in   = pix_left_ff;
      sample_idx_in = sample_idx_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      res           = '0;

      case (cur_phase)
         PH_IDLE: begin
         end
         PH_PIX: begin
            case (sample_idx_ff)
               2'd0: begin
                  red_in        = b;
                  sample_idx_in = 2'd1;
               end
               2'd1: begin
                  green_in      = b;
                  sample_idx_in = 2'd2;
               end
               default: begin
                  sample_idx_in = 2'd0;
                  pix_left_in   = pix_dec;
                  res.valid     = 1'b1;
                  res.kind      = KIND_PIXEL;
                  res.red       = red_ff;
                  res.green     = green_ff;
                  res.blue      = b;
                  if (pix_dec == '0) begin
                     res.last = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            endcase
         end
         PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
            if (cur_comment) begin
               // Skip up to and including the newline
               if (b == CHAR_NEWLINE) begin
                  comment_in = 1'b0;
               end
            end else if ((cur_tok_len == 2'd0) && is_ws) begin
               // Drop whitespace between tokens
            end else if ((cur_tok_len == 2'd0) && (b == CHAR_HASH)) begin
               comment_in = 1'b1;
            end else if (cur_phase == PH_MAGIC) begin
               // Match the two-byte magic token
               if (is_ws && (cur_tok_len == 2'd2)) begin
                  tok_len_in = 2'd0;
                  phase_in   = PH_WIDTH;
               end else if (!is_ws && (cur_tok_len == 2'd0) && (b == CHAR_P)) begin
                  tok_len_in = 2'd1;
               end else if (!is_ws && (cur_tok_len == 2'd1) && (b == CHAR_SIX)) begin
                  tok_len_in = 2'd2;
               end else begin
                  phase_in       = PH_IDLE;
                  res.valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MAGIC;
               end
            end else if (is_ws) begin
               // Close a number token
               tok_len_in = 2'd0;
               acc_in     = '0;
               if (cur_phase == PH_WIDTH) begin
                  width_in = cur_acc[DIM_BITS-1:0];
                  phase_in = PH_HEIGHT;
               end else if (cur_phase == PH_HEIGHT) begin
                  height_in = cur_acc[DIM_BITS-1:0];
                  phase_in  = PH_MAXV;
               end else if (cur_acc == '0) begin
                  phase_in       = PH_IDLE;
                  res.valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NUMBER;
               end else begin
                  pix_left_in   = PIX_BITS'(width_ff) * PIX_BITS'(height_ff);
                  sample_idx_in = 2'd0;
                  phase_in      = ((width_ff != '0) && (height_ff != '0)) ? PH_PIX : PH_IDLE;
                  res.valid     = 1'b1;
                  res.kind      = KIND_HEADER;
                  res.width     = 16'(width_ff);
                  res.height    = 16'(height_ff);
                  res.max_value = cur_acc;
               end
            end else if (!is_digit) begin
               phase_in       = PH_IDLE;
               res.valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_NUMBER;
            end else begin
               // Accumulate one decimal digit and flag oversize at once
               tok_len_in = 2'd1;
               acc_in     = acc_next[ACC_BITS-1:0];
               if (acc_next > limit) begin
                  phase_in       = PH_IDLE;
                  res.valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NUMBER;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Hold parse state, advance only when a word is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         comment_ff    <= 1'b0;
         tok_len_ff    <= 2'd0;
         acc_ff        <= '0;
         pix_left_ff   <= '0;
         sample_idx_ff <= 2'd0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         comment_ff    <= comment_in;
         tok_len_ff    <= tok_len_in;
         acc_ff        <= acc_in;
         pix_left_ff   <= pix_left_in;
         sample_idx_ff <= sample_idx_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
      end
   end

   assign result = res;

endmodule

FILE: hdl/ppm_p6_stream_parser.sv
`timescale 1ns / 1ps

// Binary PPM (P6) stream parser. Takes one file byte per clock unless stalled
// and returns at most one result word per byte: a header word on the whitespace
// byte that ends the maximum value, one pixel word on every third data byte
// (last marks the final pixel), or one error word for a bad magic or a bad or
// oversized number, after which bytes are ignored until a byte with start set.
// A byte passes an input register and one combinational parse step into the
// result register, so the block sustains one byte per cycle while the result
// is not stalled; the widest step is the width-by-height multiply that loads
// the pixel count on the header byte. A stalled result holds the output
// register while one more byte waits in the input register.
module ppm_p6_stream_parser
   import ppmp_pkg::*;
#(
   parameter int DIM_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic [15:0] rsp_max_value,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   logic            item_valid;
   ppmp_item_type   item;
   logic            out_free;
   logic            advance;
   ppmp_result_type result;
   ppmp_result_type rsp_ff;
   logic            rsp_valid_ff;

   // Advance a word when the result register is empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = item_valid && out_free;

   ppmp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_start_req (req_start_req),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   ppmp_parse #(
      .DIM_BITS (DIM_BITS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_width      = rsp_ff.width;
   assign rsp_height     = rsp_ff.height;
   assign rsp_max_value  = rsp_ff.max_value;
   assign rsp_red        = rsp_ff.red;
   assign rsp_green      = rsp_ff.green;
   assign rsp_blue       = rsp_ff.blue;
   assign rsp_error_code = rsp_ff.error_code;
   assign rsp_last       = rsp_ff.last;

endmodule
